>>> design/cdds_pkg.sv
// Shared widths, constants, reciprocal multipliers and stage structs for the date shifter.
package cdds_pkg;

  localparam int YEAR_W  = 15;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int BACK_W  = 20;
  localparam int JDN_W   = 23;

  localparam int IDX_W   = 5;
  localparam int OFS_W   = 9;

  // forward conversion
  localparam int DAYS_4YR        = 1461;
  localparam int A_PROD_W        = 26;
  localparam int A_W             = A_PROD_W - 2;
  localparam int N_W             = A_W + 1;
  localparam int SH_W            = N_W + 1;
  localparam int FWD_BASE        = 1720995;
  localparam int GREG_IN_LIMIT   = 2299171;
  localparam int CORR_W          = 9;
  localparam int LATE_MONTH_ADD  = 1;
  localparam int EARLY_MONTH_ADD = 13;
  localparam int FEB             = 2;

  localparam int CENT_DIV    = 100;
  localparam int CENT_SHIFT  = 21;
  localparam int CENT_MUL_W  = 15;
  localparam int CENT_W      = 8;
  localparam int CENT_PROD_W = (YEAR_W - 1) + CENT_MUL_W;
  localparam logic [CENT_MUL_W-1:0] CENT_MUL =
    CENT_MUL_W'(((64'd1 << CENT_SHIFT) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

  // day number back to date
  localparam int GREG_OUT_LIMIT = 2299160;
  localparam int ALPHA_BASE     = 1867216;
  localparam int X_W            = JDN_W + 2;
  localparam int ALPHA_DIV      = 146097;
  localparam int ALPHA_SHIFT    = 43;
  localparam int ALPHA_MUL_W    = 26;
  localparam int ALPHA_W        = 8;
  localparam int APROD_W        = X_W + ALPHA_MUL_W;
  localparam logic [ALPHA_MUL_W-1:0] ALPHA_MUL =
    ALPHA_MUL_W'(((64'd1 << ALPHA_SHIFT) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));

  localparam int JB_OFFSET = 1524;
  localparam int JC_OFFSET = 2442;
  localparam int NUM_W     = 28;
  localparam int JC_DIV    = 7305;
  localparam int JC_SHIFT  = 41;
  localparam int JC_MUL_W  = 29;
  localparam int JC_W      = 16;
  localparam int JPROD_W   = NUM_W + JC_MUL_W;
  localparam logic [JC_MUL_W-1:0] JC_MUL =
    JC_MUL_W'(((64'd1 << JC_SHIFT) + 64'(JC_DIV) - 64'd1) / 64'(JC_DIV));

  localparam int DAYS_YEAR = 365;
  localparam int JD_W      = JDN_W + 2;
  localparam int T_W       = 9;
  localparam int JE_NUM    = 10000;
  localparam int JE_DEN    = 306001;
  localparam int JE_SHIFT  = 28;
  localparam int JE_MUL_W  = 24;
  localparam int JE_W      = 5;
  localparam int EPROD_W   = T_W + JE_MUL_W;
  localparam logic [JE_MUL_W-1:0] JE_MUL =
    JE_MUL_W'(((64'(JE_NUM) << JE_SHIFT) + 64'(JE_DEN) - 64'd1) / 64'(JE_DEN));

  localparam int MONTHS_YEAR = 12;
  localparam int YEAR_BASE   = 4715;
  localparam int YR_W        = JC_W + 1;

  typedef struct packed {
    logic             valid;
    logic             uf;
    logic [JDN_W-1:0] num;
  } fwd_t;

  typedef struct packed {
    logic             valid;
    logic             uf;
    logic [JDN_W-1:0] num;
    logic [JDN_W-1:0] jb;
    logic [JC_W-1:0]  jc;
  } cyc_t;

  // floor(30.6001 * m)
  function automatic logic [OFS_W-1:0] month_offset(input logic [IDX_W-1:0] m);
    logic [OFS_W-1:0] r;
    unique case (m)
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/cdds_fwd.sv
// Date to Julian day number with Gregorian correction, minus the day count (3 stages).
module cdds_fwd import cdds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_take,
  input  logic signed [YEAR_W-1:0] year,
  input  logic [MONTH_W-1:0]       month,
  input  logic [DAY_W-1:0]         day,
  input  logic [BACK_W-1:0]        back,
  output fwd_t                     fwd_o
);

  logic signed [YEAR_W-1:0] y_bc;
  logic signed [YEAR_W-1:0] y_q;
  logic                     m_late;
  logic [IDX_W-1:0]         m_q;
  logic [A_PROD_W-1:0]      a_prod;
  logic [CENT_PROD_W-1:0]   cent_prod;

  logic                  v1_r, v2_r, v3_r;
  logic [A_W-1:0]        a1_r;
  logic [OFS_W-1:0]      ofs1_r;
  logic [DAY_W-1:0]      day1_r;
  logic [CENT_W-1:0]     cent1_r;
  logic [BACK_W-1:0]     back1_r;

  logic signed [N_W-1:0] n_nxt, n2_r;
  logic [CORR_W-1:0]     corr_nxt, corr2_r;
  logic [BACK_W-1:0]     back2_r;

  logic                  ge;
  logic [SH_W-1:0]       sh_nxt;
  logic                  uf3_r;
  logic [JDN_W-1:0]      num3_r;

  function automatic logic signed [YEAR_W-1:0] y_bc_sel(input logic signed [YEAR_W-1:0] y);
    logic signed [YEAR_W-1:0] r;
    r = y[YEAR_W-1] ? y + YEAR_W'(1) : y;
    return r;
  endfunction

  always_comb begin
    y_bc      = y_bc_sel(year);
    m_late    = month > MONTH_W'(FEB);
    y_q       = m_late ? y_bc : y_bc - YEAR_W'(1);
    m_q       = m_late ? {1'b0, month} + IDX_W'(LATE_MONTH_ADD)
                       : {1'b0, month} + IDX_W'(EARLY_MONTH_ADD);
    a_prod    = {{(A_PROD_W-YEAR_W){y_q[YEAR_W-1]}}, y_q} * A_PROD_W'(DAYS_4YR);
    cent_prod = CENT_PROD_W'(y_q[YEAR_W-2:0]) * CENT_PROD_W'(CENT_MUL);
  end

  always_comb begin
    n_nxt    = {a1_r[A_W-1], a1_r} + N_W'(ofs1_r) + N_W'(day1_r) + N_W'(FWD_BASE);
    corr_nxt = CORR_W'(2) - CORR_W'(cent1_r) + CORR_W'(cent1_r >> 2);
  end

  always_comb begin
    ge     = !n2_r[N_W-1] && (n2_r[N_W-2:0] >= (N_W-1)'(GREG_IN_LIMIT));
    sh_nxt = {n2_r[N_W-1], n2_r}
           + (ge ? {{(SH_W-CORR_W){corr2_r[CORR_W-1]}}, corr2_r} : '0)
           - SH_W'(back2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r    <= a_prod[A_PROD_W-1:2];
    ofs1_r  <= month_offset(m_q);
    day1_r  <= day;
    cent1_r <= cent_prod[CENT_SHIFT +: CENT_W];
    back1_r <= back;
    n2_r    <= n_nxt;
    corr2_r <= corr_nxt;
    back2_r <= back1_r;
    uf3_r   <= sh_nxt[SH_W-1];
    num3_r  <= sh_nxt[JDN_W-1:0];
  end

  always_comb begin
    fwd_o.valid = v3_r;
    fwd_o.uf    = uf3_r;
    fwd_o.num   = num3_r;
  end

endmodule

>>> design/cdds_cyc.sv
// Day number to Gregorian-corrected jb and year index jc (5 stages).
module cdds_cyc import cdds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  fwd_t fwd_i,
  output cyc_t cyc_o
);

  logic [X_W-1:0]       x_nxt;
  logic                 g_nxt;
  logic [APROD_W-1:0]   alpha_prod;
  logic [ALPHA_W-1:0]   jcorr;
  logic [JDN_W-1:0]     jb_nxt;
  logic [NUM_W-1:0]     jcn_nxt;
  logic [JPROD_W-1:0]   jc_prod;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                 uf1_r, uf2_r, uf3_r, uf4_r, uf5_r;
  logic [JDN_W-1:0]     num1_r, num2_r, num3_r, num4_r, num5_r;
  logic                 g1_r, g2_r;
  logic [X_W-1:0]       x1_r;
  logic [ALPHA_W-1:0]   alpha2_r;
  logic [JDN_W-1:0]     jb3_r, jb4_r, jb5_r;
  logic [NUM_W-1:0]     jcn4_r;
  logic [JC_W-1:0]      jc5_r;

  always_comb begin
    g_nxt      = fwd_i.num > JDN_W'(GREG_OUT_LIMIT);
    x_nxt      = {fwd_i.num, 2'b00} - X_W'(4 * ALPHA_BASE + 1);
    alpha_prod = APROD_W'(x1_r) * APROD_W'(ALPHA_MUL);
    jcorr      = ALPHA_W'(1) + alpha2_r - (alpha2_r >> 2);
    jb_nxt     = num2_r + JDN_W'(JB_OFFSET) + (g2_r ? JDN_W'(jcorr) : '0);
    jcn_nxt    = NUM_W'({jb3_r, 4'b0000}) + NUM_W'({jb3_r, 2'b00}) - NUM_W'(JC_OFFSET);
    jc_prod    = JPROD_W'(jcn4_r) * JPROD_W'(JC_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= fwd_i.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    uf1_r    <= fwd_i.uf;
    num1_r   <= fwd_i.num;
    g1_r     <= g_nxt;
    x1_r     <= x_nxt;
    uf2_r    <= uf1_r;
    num2_r   <= num1_r;
    g2_r     <= g1_r;
    alpha2_r <= alpha_prod[ALPHA_SHIFT +: ALPHA_W];
    uf3_r    <= uf2_r;
    num3_r   <= num2_r;
    jb3_r    <= jb_nxt;
    uf4_r    <= uf3_r;
    num4_r   <= num3_r;
    jb4_r    <= jb3_r;
    jcn4_r   <= jcn_nxt;
    uf5_r    <= uf4_r;
    num5_r   <= num4_r;
    jb5_r    <= jb4_r;
    jc5_r    <= jc_prod[JC_SHIFT +: JC_W];
  end

  always_comb begin
    cyc_o.valid = v5_r;
    cyc_o.uf    = uf5_r;
    cyc_o.num   = num5_r;
    cyc_o.jb    = jb5_r;
    cyc_o.jc    = jc5_r;
  end

endmodule

>>> design/cdds_ymd.sv
// jb/jc to year, month and day, result registers with underflow zeroing (4 stages).
module cdds_ymd import cdds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cyc_t                     cyc_i,
  output logic                     out_valid,
  output logic signed [YEAR_W-1:0] out_year,
  output logic [MONTH_W-1:0]       out_month,
  output logic [DAY_W-1:0]         out_day,
  output logic [JDN_W-1:0]         out_num,
  output logic                     out_uf
);

  logic [JD_W-1:0]        jd_full;
  logic [JDN_W-1:0]       t_diff;
  logic signed [YR_W-1:0] ybase_nxt;
  logic [EPROD_W-1:0]     je_prod;
  logic [IDX_W-1:0]       mon0;
  logic [IDX_W-1:0]       mon;
  logic [OFS_W-1:0]       day_full;
  logic signed [YR_W-1:0] yr0;
  logic signed [YR_W-1:0] yr;

  logic                   v1_r, v2_r, v3_r, v4_r;
  logic                   uf1_r, uf2_r, uf3_r;
  logic [JDN_W-1:0]       num1_r, num2_r, num3_r;
  logic [JDN_W-1:0]       jb1_r, jd1_r;
  logic [JC_W-1:0]        jc1_r;
  logic [T_W-1:0]         t2_r, t3_r;
  logic signed [YR_W-1:0] ybase2_r, ybase3_r;
  logic [JE_W-1:0]        je3_r;

  logic signed [YEAR_W-1:0] year4_r;
  logic [MONTH_W-1:0]       month4_r;
  logic [DAY_W-1:0]         day4_r;
  logic [JDN_W-1:0]         num4_r;
  logic                     uf4_r;

  always_comb begin
    jd_full   = JD_W'(cyc_i.jc) * JD_W'(DAYS_YEAR) + JD_W'(cyc_i.jc >> 2);
    t_diff    = jb1_r - jd1_r;
    ybase_nxt = YR_W'(jc1_r) - YR_W'(YEAR_BASE);
    je_prod   = EPROD_W'(t2_r) * EPROD_W'(JE_MUL);
    mon0      = je3_r - IDX_W'(1);
    mon       = (mon0 > IDX_W'(MONTHS_YEAR)) ? mon0 - IDX_W'(MONTHS_YEAR) : mon0;
    day_full  = t3_r - month_offset(je3_r);
    yr0       = (mon > IDX_W'(FEB)) ? ybase3_r - YR_W'(1) : ybase3_r;
    yr        = (yr0[YR_W-1] || yr0 == '0) ? yr0 - YR_W'(1) : yr0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cyc_i.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    uf1_r    <= cyc_i.uf;
    num1_r   <= cyc_i.num;
    jb1_r    <= cyc_i.jb;
    jc1_r    <= cyc_i.jc;
    jd1_r    <= jd_full[JDN_W-1:0];
    uf2_r    <= uf1_r;
    num2_r   <= num1_r;
    t2_r     <= t_diff[T_W-1:0];
    ybase2_r <= ybase_nxt;
    uf3_r    <= uf2_r;
    num3_r   <= num2_r;
    t3_r     <= t2_r;
    ybase3_r <= ybase2_r;
    je3_r    <= je_prod[JE_SHIFT +: JE_W];
    uf4_r    <= uf3_r;
    if (uf3_r) begin
      year4_r  <= '0;
      month4_r <= '0;
      day4_r   <= '0;
      num4_r   <= '0;
    end else begin
      year4_r  <= yr[YEAR_W-1:0];
      month4_r <= mon[MONTH_W-1:0];
      day4_r   <= day_full[DAY_W-1:0];
      num4_r   <= num3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_year  = year4_r;
  assign out_month = month4_r;
  assign out_day   = day4_r;
  assign out_num   = num4_r;
  assign out_uf    = uf4_r;

endmodule

>>> design/calendar_date_day_shift.sv
// Calendar date shifter: date minus day count, returned as date and Julian day number.
// Path: start is registered through the fwd, cyc and ymd stage registers to out_valid.
// Throughput: one word per cycle; busy never rises, set by the 12-stage register pipeline.
// Each result is shown for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears all stage valid bits; words in flight are dropped.
module calendar_date_day_shift import cdds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [YEAR_W-1:0] in_year_in,
  input  logic [MONTH_W-1:0]       in_month_in,
  input  logic [DAY_W-1:0]         in_day_in,
  input  logic [BACK_W-1:0]        in_days_back,
  output logic                     out_valid,
  output logic signed [YEAR_W-1:0] out_year_out,
  output logic [MONTH_W-1:0]       out_month_out,
  output logic [DAY_W-1:0]         out_day_out,
  output logic [JDN_W-1:0]         out_shifted_day_number,
  output logic                     out_underflow
);

  logic in_take;
  fwd_t fwd;
  cyc_t cyc;

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  cdds_fwd u_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .year    (in_year_in),
    .month   (in_month_in),
    .day     (in_day_in),
    .back    (in_days_back),
    .fwd_o   (fwd)
  );

  cdds_cyc u_cyc (
    .clk   (clk),
    .rst_n (rst_n),
    .fwd_i (fwd),
    .cyc_o (cyc)
  );

  cdds_ymd u_ymd (
    .clk       (clk),
    .rst_n     (rst_n),
    .cyc_i     (cyc),
    .out_valid (out_valid),
    .out_year  (out_year_out),
    .out_month (out_month_out),
    .out_day   (out_day_out),
    .out_num   (out_shifted_day_number),
    .out_uf    (out_underflow)
  );

endmodule
